>>> sv/ean13_pkg.sv
// Package for the EAN-13 bar pattern encoder: symbol code tables, parity
// patterns, segment constants and shared types.
// No dependencies.
`timescale 1ns / 1ps

package ean13_pkg;

    typedef logic [3:0] digit_t;
    typedef logic [6:0] bars_t;
    typedef logic [3:0] seg_idx_t;
    typedef logic [2:0] mod_cnt_t;

    localparam int NUM_DIGITS = 12;
    localparam int NUM_SEG    = 15;

    localparam seg_idx_t SEG_START  = 4'd0;
    localparam seg_idx_t SEG_CENTER = 4'd7;
    localparam seg_idx_t SEG_END    = 4'd14;

    localparam bars_t GUARD_BITS  = 7'h05;
    localparam bars_t CENTER_BITS = 7'h0A;

    localparam mod_cnt_t GUARD_COUNT  = 3'd3;
    localparam mod_cnt_t CENTER_COUNT = 3'd5;
    localparam mod_cnt_t SYMBOL_COUNT = 3'd7;

    localparam digit_t MAX_DIGIT = 4'd9;

    // field above nine counts as zero
    function automatic digit_t clean_digit(input digit_t d);
        return (d > MAX_DIGIT) ? 4'd0 : d;
    endfunction

    // L codes, first module in bit 6
    function automatic bars_t code_l(input digit_t d);
        case (d)
            4'd0:    return 7'h0D;
            4'd1:    return 7'h19;
            4'd2:    return 7'h13;
            4'd3:    return 7'h3D;
            4'd4:    return 7'h23;
            4'd5:    return 7'h31;
            4'd6:    return 7'h2F;
            4'd7:    return 7'h3B;
            4'd8:    return 7'h37;
            4'd9:    return 7'h0B;
            default: return 7'h0D;
        endcase
    endfunction

    // G codes
    function automatic bars_t code_g(input digit_t d);
        case (d)
            4'd0:    return 7'h27;
            4'd1:    return 7'h33;
            4'd2:    return 7'h1B;
            4'd3:    return 7'h21;
            4'd4:    return 7'h1D;
            4'd5:    return 7'h39;
            4'd6:    return 7'h05;
            4'd7:    return 7'h11;
            4'd8:    return 7'h09;
            4'd9:    return 7'h17;
            default: return 7'h27;
        endcase
    endfunction

    // R codes
    function automatic bars_t code_r(input digit_t d);
        case (d)
            4'd0:    return 7'h72;
            4'd1:    return 7'h66;
            4'd2:    return 7'h6C;
            4'd3:    return 7'h42;
            4'd4:    return 7'h5C;
            4'd5:    return 7'h4E;
            4'd6:    return 7'h50;
            4'd7:    return 7'h44;
            4'd8:    return 7'h48;
            4'd9:    return 7'h74;
            default: return 7'h72;
        endcase
    endfunction

    // left-half parity: bit 5 is left symbol 1, 1 selects G
    function automatic logic [5:0] parity_mask(input digit_t d);
        case (d)
            4'd0:    return 6'h00;
            4'd1:    return 6'h0B;
            4'd2:    return 6'h0D;
            4'd3:    return 6'h0E;
            4'd4:    return 6'h13;
            4'd5:    return 6'h19;
            4'd6:    return 6'h1C;
            4'd7:    return 6'h15;
            4'd8:    return 6'h16;
            4'd9:    return 6'h1A;
            default: return 6'h00;
        endcase
    endfunction

    // modules in a segment, by its index
    function automatic mod_cnt_t seg_count(input seg_idx_t s);
        if (s == SEG_START || s == SEG_END)
        begin
            return GUARD_COUNT;
        end
        else if (s == SEG_CENTER)
        begin
            return CENTER_COUNT;
        end
        return SYMBOL_COUNT;
    endfunction

endpackage

>>> sv/ean13_barcode_encoder.sv
// EAN-13 bar pattern encoder top level: check digit pipeline and segment
// serializer. Depends on ean13_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input stream (s_axis_*): one transfer carries the twelve leading digits
//   of an EAN-13 number. Output stream (m_axis_*): 15 transfers per number,
//   start guard, six left symbols, center guard, six right symbols (the last
//   is the check digit) and end guard; tlast marks the end guard.
//   The first segment passes stages 1 to 3, the serializer and the output
//   register before it is presented; the rest follow one per cycle while
//   the receiver takes them, and the output port, which moves one segment
//   per cycle, sets the pace. Three pipeline stages (clean and partial sums,
//   total sum, check digit and parity) feed a 15-entry segment shift
//   register, so the next number is fully prepared while the current one is
//   being sent and follows its end guard without a gap.
//   Stall: when m_axis_tready is low the output register holds, and the
//   serializer and pipeline stages fill up and then drop s_axis_tready;
//   nothing is lost or repeated.
//   Reset: rst_n clears all valid flags and the segment counter; the block
//   accepts input in the first cycle after reset is released.
module ean13_barcode_encoder
    import ean13_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // lead_digit[3:0], digit_1[7:4], ... digit_11[47:44]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // segment_index[3:0], module_bits[10:4], module_count[13:11],
    // check_digit[17:14], zero[23:18]
    output logic [23:0] m_axis_tdata,
    // is_last
    output logic        m_axis_tlast
);

    // ---------------------------------------------------------------
    // Handshake chain
    // ---------------------------------------------------------------
    logic     s1_v_reg, s2_v_reg, s3_v_reg, ser_v_reg, out_v_reg;
    seg_idx_t ser_cnt_reg;
    logic     out_free, ser_step, ser_free, s3_ready, s2_ready, s1_ready;

    assign out_free = !out_v_reg || m_axis_tready;
    assign ser_step = ser_v_reg && out_free;
    assign ser_free = !ser_v_reg || (ser_step && ser_cnt_reg == SEG_END);
    assign s3_ready = !s3_v_reg || ser_free;
    assign s2_ready = !s2_v_reg || s3_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    // ---------------------------------------------------------------
    // Stage 1: clean digits, weighted partial sums of each half
    // ---------------------------------------------------------------
    digit_t      s1_dig_next [NUM_DIGITS];
    logic [6:0]  s1_lo_next, s1_hi_next;
    digit_t      s1_dig_reg  [NUM_DIGITS];
    logic [6:0]  s1_lo_reg, s1_hi_reg;

    always_comb
    begin
        logic [5:0] w;
        s1_lo_next = '0;
        s1_hi_next = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            s1_dig_next[i] = clean_digit(s_axis_tdata[4*i +: 4]);
        end
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            // odd positions weigh 3
            w = (i % 2 == 1) ? ({1'b0, s1_dig_next[i], 1'b0} + {2'b00, s1_dig_next[i]})
                             : {2'b00, s1_dig_next[i]};
            if (i < NUM_DIGITS / 2)
            begin
                s1_lo_next = s1_lo_next + {1'b0, w};
            end
            else
            begin
                s1_hi_next = s1_hi_next + {1'b0, w};
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: total sum
    // ---------------------------------------------------------------
    digit_t     s2_dig_reg [NUM_DIGITS];
    logic [7:0] s2_sum_reg;
    logic [7:0] s2_sum_next;

    assign s2_sum_next = {1'b0, s1_lo_reg} + {1'b0, s1_hi_reg};

    // ---------------------------------------------------------------
    // Stage 3: check digit (sum mod 10 by reciprocal), parity pattern
    // ---------------------------------------------------------------
    logic [15:0] s3_prod;
    logic [4:0]  s3_quot;
    logic [7:0]  s3_rem;
    digit_t      s3_chk_next;
    logic [5:0]  s3_par_next;
    digit_t      s3_dig_reg [NUM_DIGITS];
    digit_t      s3_chk_reg;
    logic [5:0]  s3_par_reg;

    always_comb
    begin
        // sum * 205 / 2048 is exact floor(sum / 10) for sums below 256
        s3_prod = {8'd0, s2_sum_reg} * 16'd205;
        s3_quot = s3_prod[15:11];
        s3_rem  = s2_sum_reg - ({s3_quot, 3'd0} + {2'd0, s3_quot, 1'b0});
        s3_chk_next = (s3_rem[3:0] == 4'd0) ? 4'd0 : 4'd10 - s3_rem[3:0];
        s3_par_next = parity_mask(s2_dig_reg[0]);
    end

    // ---------------------------------------------------------------
    // Serializer load: code all 15 segments
    // ---------------------------------------------------------------
    bars_t  ser_bits_next [NUM_SEG];
    bars_t  ser_bits_reg  [NUM_SEG];
    digit_t ser_chk_reg;

    always_comb
    begin
        ser_bits_next[0]  = GUARD_BITS;
        for (int i = 1; i <= 6; i++)
        begin
            ser_bits_next[i] = s3_par_reg[6 - i] ? code_g(s3_dig_reg[i])
                                                 : code_l(s3_dig_reg[i]);
        end
        ser_bits_next[7]  = CENTER_BITS;
        for (int i = 8; i <= 12; i++)
        begin
            ser_bits_next[i] = code_r(s3_dig_reg[i - 1]);
        end
        ser_bits_next[13] = code_r(s3_chk_reg);
        ser_bits_next[14] = GUARD_BITS;
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            ser_v_reg   <= 1'b0;
            ser_cnt_reg <= SEG_START;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_v_reg <= s_axis_tvalid;
            end
            if (s2_ready)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ready)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (ser_free)
            begin
                ser_v_reg   <= s3_v_reg;
                ser_cnt_reg <= SEG_START;
            end
            else if (ser_step)
            begin
                ser_cnt_reg <= ser_cnt_reg + 4'd1;
            end
            if (out_free)
            begin
                out_v_reg <= ser_v_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    seg_idx_t out_idx_reg;
    bars_t    out_bits_reg;
    mod_cnt_t out_cnt_reg;
    digit_t   out_chk_reg;
    logic     out_last_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready && s_axis_tvalid)
        begin
            s1_dig_reg <= s1_dig_next;
            s1_lo_reg  <= s1_lo_next;
            s1_hi_reg  <= s1_hi_next;
        end
        if (s2_ready && s1_v_reg)
        begin
            s2_dig_reg <= s1_dig_reg;
            s2_sum_reg <= s2_sum_next;
        end
        if (s3_ready && s2_v_reg)
        begin
            s3_dig_reg <= s2_dig_reg;
            s3_chk_reg <= s3_chk_next;
            s3_par_reg <= s3_par_next;
        end
        if (ser_free && s3_v_reg)
        begin
            ser_bits_reg <= ser_bits_next;
            ser_chk_reg  <= s3_chk_reg;
        end
        else if (ser_step)
        begin
            // shift next segment down to the read tap
            for (int i = 0; i < NUM_SEG - 1; i++)
            begin
                ser_bits_reg[i] <= ser_bits_reg[i + 1];
            end
        end
        if (ser_step)
        begin
            out_idx_reg  <= ser_cnt_reg;
            out_bits_reg <= ser_bits_reg[0];
            out_cnt_reg  <= seg_count(ser_cnt_reg);
            out_chk_reg  <= ser_chk_reg;
            out_last_reg <= (ser_cnt_reg == SEG_END);
        end
    end

    // ---------------------------------------------------------------
    // Output port
    // ---------------------------------------------------------------
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {6'd0, out_chk_reg, out_cnt_reg, out_bits_reg, out_idx_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
